>>> rtl/gcdist_pkg.sv
package gcdist_pkg;

  localparam int unsigned LAT_W    = 24;
  localparam int unsigned LON_W    = 25;
  localparam int unsigned RADIUS_W = 24;
  localparam int unsigned ARC_W    = 34;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

  // Angles are carried as Q30 radians in 32-bit signed words.
  localparam int unsigned ANG_W        = 32;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 32;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [30:0]             ONE_Q30     = 31'd1073741824;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'sd843314856;
      1:  v = 32'sd497837829;
      2:  v = 32'sd263043836;
      3:  v = 32'sd133525158;
      4:  v = 32'sd67021686;
      5:  v = 32'sd33543515;
      6:  v = 32'sd16775850;
      7:  v = 32'sd8388437;
      8:  v = 32'sd4194282;
      9:  v = 32'sd2097149;
      10: v = 32'sd1048575;
      11: v = 32'sd524287;
      12: v = 32'sd262143;
      13: v = 32'sd131071;
      14: v = 32'sd65535;
      15: v = 32'sd32767;
      16: v = 32'sd16383;
      17: v = 32'sd8191;
      18: v = 32'sd4095;
      19: v = 32'sd2047;
      20: v = 32'sd1023;
      21: v = 32'sd511;
      22: v = 32'sd255;
      23: v = 32'sd127;
      24: v = 32'sd63;
      25: v = 32'sd31;
      26: v = 32'sd15;
      27: v = 32'sd8;
      28: v = 32'sd4;
      29: v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One step of the restoring integer square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] b);
    logic [63:0] trial;
    sqrt_t r;
    trial = s.root + b;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

>>> rtl/great_circle_distance_top.sv
// Great-circle distance between two points given as latitude and longitude in
// degrees (Q16). The block is a fully pipelined datapath: one item is accepted
// every cycle while out_ready is high or the pipeline has a bubble. The pipeline
// holds the two 30-step CORDIC units and the two 32-step square root units laid
// out one step per stage. Each stage holds its item until the next stage can
// take it, so a stalled output fills bubbles first and only then deasserts
// in_ready. The radius register applies to every item still in flight, so write
// it only when the pipeline is empty.
module great_circle_distance_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [gcdist_pkg::RADIUS_W-1:0]       cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gcdist_pkg::LAT_W-1:0]   in_lat_a,
  input  logic signed [gcdist_pkg::LON_W-1:0]   in_lon_a,
  input  logic signed [gcdist_pkg::LAT_W-1:0]   in_lat_b,
  input  logic signed [gcdist_pkg::LON_W-1:0]   in_lon_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [gcdist_pkg::ARC_W-1:0]          out_arc_length
);

  localparam int unsigned ROT_N = gcdist_pkg::CORDIC_STEPS;
  localparam int unsigned SQ_N  = gcdist_pkg::SQRT_STEPS;

  localparam int unsigned ST_RED  = 0;
  localparam int unsigned ST_MUL  = ST_RED + 1;
  localparam int unsigned ST_ROT0 = ST_MUL + 1;
  localparam int unsigned ST_FLIP = ST_ROT0 + ROT_N + 1;
  localparam int unsigned ST_VEC  = ST_FLIP + 1;
  localparam int unsigned ST_SQ   = ST_VEC + 1;
  localparam int unsigned ST_SQA0 = ST_SQ + 1;
  localparam int unsigned ST_H    = ST_SQA0 + SQ_N + 1;
  localparam int unsigned ST_SQB0 = ST_H + 1;
  localparam int unsigned ST_VC0  = ST_SQB0 + SQ_N + 1;
  localparam int unsigned ST_OUT  = ST_VC0 + ROT_N + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  localparam int unsigned ANGIN_W = 26;
  localparam int unsigned MAG_W   = 23;

  localparam logic signed [ANGIN_W-1:0] DEG360 = 26'sd23592960;
  localparam logic signed [ANGIN_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANGIN_W-1:0] DEG90  = 26'sd5898240;

  // pi/4 in Q30 over 45 degrees in Q16 is split as 45*KQ + KR over 45*2^16,
  // so the divide by 45 only sees a narrow remainder term.
  localparam logic [24:0] KQ      = 25'd18740330;
  localparam logic [25:0] KR      = 26'd7;
  localparam logic [25:0] HALF45  = 26'd1474560;
  localparam logic [26:0] RECIP45 = 27'd95443718;

  typedef struct packed {
    logic             flip;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } fold_t;

  function automatic fold_t fold_angle(input logic signed [ANGIN_W-1:0] a);
    logic signed [ANGIN_W-1:0] m;
    logic signed [ANGIN_W-1:0] am;
    fold_t f;
    m = a;
    f.flip = 1'b0;
    priority if (m >= DEG180) begin
      m = m - DEG360;
    end else if (m < -DEG180) begin
      m = m + DEG360;
    end else begin
      m = m;
    end
    priority if (m > DEG90) begin
      m = m - DEG180;
      f.flip = 1'b1;
    end else if (m < -DEG90) begin
      m = m + DEG180;
      f.flip = 1'b1;
    end else begin
      m = m;
    end
    f.neg = (m < 0);
    am = (m < 0) ? -m : m;
    f.mag = am[MAG_W-1:0];
    return f;
  endfunction

  // Handshake: a stage loads when it is empty or its item moves on.
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;

  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = out_ready | ~(&v_r[NST-1:i]);
  end

  assign v_nxt    = (en & {v_r[NST-2:0], in_valid}) | (~en & v_r);
  assign in_ready = en[0];

  logic [gcdist_pkg::RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      radius_r <= gcdist_pkg::RADIUS_RESET;
    end else begin
      v_r <= v_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
    end
  end

  // Range reduction of the four angles.
  fold_t fold_r [0:3];

  always_ff @(posedge clk) begin
    if (en[ST_RED]) begin
      fold_r[0] <= fold_angle(ANGIN_W'(in_lat_a));
      fold_r[1] <= fold_angle(ANGIN_W'(in_lon_a));
      fold_r[2] <= fold_angle(ANGIN_W'(in_lat_b));
      fold_r[3] <= fold_angle(ANGIN_W'(in_lon_b));
    end
  end

  // Degrees to radians: magnitude times KQ, plus the remainder term over 45.
  logic [47:0] prod_r [0:3];
  logic [20:0] nq_r   [0:3];
  logic        s1_neg_r  [0:3];
  logic        s1_flip_r [0:3];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int j = 0; j < 4; j++) begin
        logic [25:0] nsum;
        logic [52:0] nprod;
        nsum  = 26'(fold_r[j].mag) * KR + HALF45;
        nprod = 53'(nsum) * 53'(RECIP45);
        prod_r[j]    <= 48'(fold_r[j].mag) * 48'(KQ);
        nq_r[j]      <= nprod[52:32];
        s1_neg_r[j]  <= fold_r[j].neg;
        s1_flip_r[j] <= fold_r[j].flip;
      end
    end
  end

  // Rotation CORDIC, one step per stage for all four angles.
  logic signed [gcdist_pkg::ANG_W-1:0] rx_r [0:ROT_N][0:3];
  logic signed [gcdist_pkg::ANG_W-1:0] ry_r [0:ROT_N][0:3];
  logic signed [gcdist_pkg::ANG_W-1:0] rz_r [0:ROT_N][0:3];
  logic                                rf_r [0:ROT_N][0:3];

  always_ff @(posedge clk) begin
    if (en[ST_ROT0]) begin
      for (int j = 0; j < 4; j++) begin
        logic [47:0] t;
        logic signed [31:0] q;
        t = prod_r[j] + 48'(nq_r[j]);
        q = t[47:16];
        rz_r[0][j] <= s1_neg_r[j] ? -q : q;
        rx_r[0][j] <= gcdist_pkg::CORDIC_GAIN;
        ry_r[0][j] <= '0;
        rf_r[0][j] <= s1_flip_r[j];
      end
    end
    for (int k = 0; k < ROT_N; k++) begin
      if (en[ST_ROT0+k+1]) begin
        for (int j = 0; j < 4; j++) begin
          if (rz_r[k][j] >= 0) begin
            rx_r[k+1][j] <= rx_r[k][j] - (ry_r[k][j] >>> k);
            ry_r[k+1][j] <= ry_r[k][j] + (rx_r[k][j] >>> k);
            rz_r[k+1][j] <= rz_r[k][j] - gcdist_pkg::atan_q30(k);
          end else begin
            rx_r[k+1][j] <= rx_r[k][j] + (ry_r[k][j] >>> k);
            ry_r[k+1][j] <= ry_r[k][j] - (rx_r[k][j] >>> k);
            rz_r[k+1][j] <= rz_r[k][j] + gcdist_pkg::atan_q30(k);
          end
          rf_r[k+1][j] <= rf_r[k][j];
        end
      end
    end
  end

  logic signed [31:0] sn_r [0:3];
  logic signed [31:0] cs_r [0:3];

  always_ff @(posedge clk) begin
    if (en[ST_FLIP]) begin
      for (int j = 0; j < 4; j++) begin
        sn_r[j] <= rf_r[ROT_N][j] ? -ry_r[ROT_N][j] : ry_r[ROT_N][j];
        cs_r[j] <= rf_r[ROT_N][j] ? -rx_r[ROT_N][j] : rx_r[ROT_N][j];
      end
    end
  end

  // Unit vectors: x = cos lat sin lon, y = cos lat cos lon, z = sin lat.
  logic signed [31:0] va_r [0:2];
  logic signed [31:0] vb_r [0:2];

  always_ff @(posedge clk) begin
    if (en[ST_VEC]) begin
      logic signed [63:0] pa0, pa1, pb0, pb1;
      pa0 = 64'(cs_r[0]) * 64'(sn_r[1]);
      pa1 = 64'(cs_r[0]) * 64'(cs_r[1]);
      pb0 = 64'(cs_r[2]) * 64'(sn_r[3]);
      pb1 = 64'(cs_r[2]) * 64'(cs_r[3]);
      pa0 = pa0 >>> 30;
      pa1 = pa1 >>> 30;
      pb0 = pb0 >>> 30;
      pb1 = pb1 >>> 30;
      va_r[0] <= pa0[31:0];
      va_r[1] <= pa1[31:0];
      va_r[2] <= sn_r[0];
      vb_r[0] <= pb0[31:0];
      vb_r[1] <= pb1[31:0];
      vb_r[2] <= sn_r[2];
    end
  end

  logic [63:0] sq_r [0:2];

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [32:0] d;
        logic signed [32:0] ad;
        d  = 33'(va_r[j]) - 33'(vb_r[j]);
        ad = (d < 0) ? -d : d;
        sq_r[j] <= 64'(ad[31:0]) * 64'(ad[31:0]);
      end
    end
  end

  // Chord length: square root of the summed squares, Q60 to Q30.
  gcdist_pkg::sqrt_t sa_r [0:SQ_N];

  always_ff @(posedge clk) begin
    if (en[ST_SQA0]) begin
      sa_r[0].rem  <= sq_r[0] + sq_r[1] + sq_r[2];
      sa_r[0].root <= '0;
    end
    for (int k = 0; k < SQ_N; k++) begin
      if (en[ST_SQA0+k+1]) begin
        sa_r[k+1] <= gcdist_pkg::sqrt_step(sa_r[k], 64'(1) << (62 - 2 * k));
      end
    end
  end

  logic [30:0] h_r;

  always_ff @(posedge clk) begin
    if (en[ST_H]) begin
      logic [63:0] hh;
      hh = sa_r[SQ_N].root >> 1;
      h_r <= (hh > 64'(gcdist_pkg::ONE_Q30)) ? gcdist_pkg::ONE_Q30 : hh[30:0];
    end
  end

  // Cosine of the half angle: sqrt(1 - h^2).
  gcdist_pkg::sqrt_t sb_r [0:SQ_N];
  logic [30:0]       th_r [0:SQ_N];

  always_ff @(posedge clk) begin
    if (en[ST_SQB0]) begin
      sb_r[0].rem  <= (64'(1) << 60) - 64'(h_r) * 64'(h_r);
      sb_r[0].root <= '0;
      th_r[0]      <= h_r;
    end
    for (int k = 0; k < SQ_N; k++) begin
      if (en[ST_SQB0+k+1]) begin
        sb_r[k+1] <= gcdist_pkg::sqrt_step(sb_r[k], 64'(1) << (62 - 2 * k));
        th_r[k+1] <= th_r[k];
      end
    end
  end

  // Arcsine as atan2(h, sqrt(1 - h^2)) by vectoring CORDIC.
  logic signed [gcdist_pkg::ANG_W-1:0] ax_r [0:ROT_N];
  logic signed [gcdist_pkg::ANG_W-1:0] ay_r [0:ROT_N];
  logic signed [gcdist_pkg::ANG_W-1:0] az_r [0:ROT_N];

  always_ff @(posedge clk) begin
    if (en[ST_VC0]) begin
      ax_r[0] <= sb_r[SQ_N].root[31:0];
      ay_r[0] <= 32'(th_r[SQ_N]);
      az_r[0] <= '0;
    end
    for (int k = 0; k < ROT_N; k++) begin
      if (en[ST_VC0+k+1]) begin
        if (ay_r[k] > 0) begin
          ax_r[k+1] <= ax_r[k] + (ay_r[k] >>> k);
          ay_r[k+1] <= ay_r[k] - (ax_r[k] >>> k);
          az_r[k+1] <= az_r[k] + gcdist_pkg::atan_q30(k);
        end else begin
          ax_r[k+1] <= ax_r[k] - (ay_r[k] >>> k);
          ay_r[k+1] <= ay_r[k] + (ax_r[k] >>> k);
          az_r[k+1] <= az_r[k] - gcdist_pkg::atan_q30(k);
        end
      end
    end
  end

  // Scale by the radius with rounding to 8 fractional bits.
  logic [gcdist_pkg::ARC_W-1:0] arc_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      logic [30:0] ang;
      logic [55:0] full;
      ang  = (az_r[ROT_N] < 0) ? '0 : az_r[ROT_N][30:0];
      full = 56'(radius_r) * 56'(ang) + (56'(1) << 20);
      arc_r <= full[54:21];
    end
  end

  assign out_valid      = v_r[ST_OUT];
  assign out_arc_length = arc_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_h_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_H] |-> (h_r <= gcdist_pkg::ONE_Q30))
    else $error("arcsine argument above one");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
      + int'($past(in_valid & in_ready)) - int'($past(out_valid & out_ready))))
    else $error("item lost or duplicated in the pipeline");

endmodule
